FILE: src/ett_pkg.sv
`timescale 1ns / 1ps

package ett_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DECIDE,
        ST_MUL,
        ST_FACTOR,
        ST_FINAL_MUL,
        ST_FINAL,
        ST_PUBLISH
    } ett_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_STEP,
        OP_ADVANCE,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_FACTOR,
        OP_TAKE_PROD,
        OP_PUBLISH
    } ett_op_t;

    typedef enum logic [1:0] {
        MSEL_D_MINUS_1,
        MSEL_D,
        MSEL_N_MINUS_1
    } ett_mul_sel_t;

    typedef struct packed {
        ett_op_t      op;
        ett_mul_sel_t sel;
    } ett_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic q_ge_d;
        logic rem_zero;
        logic n_gt1;
        logic first;
    } ett_status_t;

    localparam int unsigned FIELD_WIDTH = 32;

endpackage

FILE: src/ett_ctrl.sv
`timescale 1ns / 1ps

module ett_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ett_pkg::ett_status_t status,
    output ett_pkg::ett_cmd_t    cmd
);
    import ett_pkg::*;

    ett_state_t state_reg;
    ett_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = OP_NONE;
        cmd.sel        = MSEL_D;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.cnt_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (status.rem_zero && (!status.first || status.q_ge_d))
                begin
                    cmd.op     = OP_MUL_INIT;
                    cmd.sel    = status.first ? MSEL_D_MINUS_1 : MSEL_D;
                    state_next = ST_MUL;
                end
                else if (!status.first || status.q_ge_d)
                begin
                    cmd.op     = OP_ADVANCE;
                    state_next = ST_DIV;
                end
                else if (status.n_gt1)
                begin
                    cmd.op     = OP_MUL_INIT;
                    cmd.sel    = MSEL_N_MINUS_1;
                    state_next = ST_FINAL_MUL;
                end
                else
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_MUL:
            begin
                cmd.op = OP_MUL_STEP;
                if (status.cnt_last)
                begin
                    state_next = ST_FACTOR;
                end
            end
            ST_FACTOR:
            begin
                cmd.op     = OP_FACTOR;
                state_next = ST_DIV;
            end
            ST_FINAL_MUL:
            begin
                cmd.op = OP_MUL_STEP;
                if (status.cnt_last)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.op     = OP_TAKE_PROD;
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: src/ett_datapath.sv
`timescale 1ns / 1ps

module ett_datapath #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                 clk,
    input  logic [ett_pkg::FIELD_WIDTH-1:0] value,
    input  ett_pkg::ett_cmd_t    cmd,
    output ett_pkg::ett_status_t status,
    output logic [ett_pkg::FIELD_WIDTH-1:0] totient
);
    import ett_pkg::*;

    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned CW = $clog2(W);
    localparam logic [CW-1:0] CNT_TOP = CW'(W - 1);

    logic [W-1:0]           n_reg, n_next;
    logic [W-1:0]           d_reg, d_next;
    logic [W-1:0]           acc_reg, acc_next;
    logic                   first_reg, first_next;
    logic [W-1:0]           quo_reg, quo_next;
    logic [W-1:0]           rem_reg, rem_next;
    logic [W-1:0]           prod_reg, prod_next;
    logic [W-1:0]           mcand_reg, mcand_next;
    logic [W-1:0]           mplier_reg, mplier_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [FIELD_WIDTH-1:0] result_reg, result_next;

    logic [W-1:0] in_w;
    logic [W:0]   rem_sh;
    logic         rem_ge;

    assign in_w   = W'(value);
    assign rem_sh = {rem_reg, quo_reg[W-1]};
    assign rem_ge = (rem_sh >= {1'b0, d_reg});

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        d_reg      <= d_next;
        acc_reg    <= acc_next;
        first_reg  <= first_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        n_next      = n_reg;
        d_next      = d_reg;
        acc_next    = acc_reg;
        first_next  = first_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                n_next     = in_w;
                acc_next   = (in_w == '0) ? '0 : W'(1);
                d_next     = W'(2);
                first_next = 1'b1;
                quo_next   = in_w;
                rem_next   = '0;
                cnt_next   = CNT_TOP;
            end
            OP_DIV_STEP:
            begin
                quo_next = {quo_reg[W-2:0], rem_ge};
                rem_next = rem_ge ? W'(rem_sh - {1'b0, d_reg}) : rem_sh[W-1:0];
                cnt_next = cnt_reg - 1'b1;
            end
            OP_ADVANCE:
            begin
                d_next     = d_reg + ((d_reg == W'(2)) ? W'(1) : W'(2));
                first_next = 1'b1;
                quo_next   = n_reg;
                rem_next   = '0;
                cnt_next   = CNT_TOP;
            end
            OP_MUL_INIT:
            begin
                prod_next  = '0;
                mcand_next = acc_reg;
                unique case (cmd.sel)
                    MSEL_D_MINUS_1: mplier_next = d_reg - W'(1);
                    MSEL_D:         mplier_next = d_reg;
                    MSEL_N_MINUS_1: mplier_next = n_reg - W'(1);
                    default:        mplier_next = d_reg;
                endcase
                cnt_next = CNT_TOP;
            end
            OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                begin
                    prod_next = prod_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[W-1:1]};
                cnt_next    = cnt_reg - 1'b1;
            end
            OP_FACTOR:
            begin
                acc_next   = prod_reg;
                n_next     = quo_reg;
                first_next = 1'b0;
                rem_next   = '0;
                cnt_next   = CNT_TOP;
            end
            OP_TAKE_PROD:
            begin
                acc_next = prod_reg;
            end
            OP_PUBLISH:
            begin
                result_next = FIELD_WIDTH'(acc_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign status.cnt_last = (cnt_reg == '0);
    assign status.q_ge_d   = (quo_reg >= d_reg);
    assign status.rem_zero = (rem_reg == '0);
    assign status.n_gt1    = (n_reg > W'(1));
    assign status.first    = first_reg;
    assign totient         = result_reg;

endmodule

FILE: src/euler_totient_trial_division_unit.sv
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     in_valid / in_ready   value   [31:0]
// output    out_valid / out_ready totient [31:0]
//
// One transaction at a time. Each trial divisor is tested in the bit-serial restoring
// divider; each factor found adds a pass through the shift-add multiplier.
// rst_n clears the controller and the output valid flag only.
// A finished result waits in the output register; in_ready rises once it is loaded there.

module euler_totient_trial_division_unit #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] totient
);
    import ett_pkg::*;

    ett_cmd_t    cmd;
    ett_status_t status;

    ett_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ett_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .value   (value),
        .cmd     (cmd),
        .status  (status),
        .totient (totient)
    );

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input accepted while a transaction is in progress");

    a_publish_ends_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (in_ready && !$past(in_ready))
    ) else $error("result published without completing a transaction");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ett_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 10000000;
    localparam int unsigned RANDOM_ITEMS   = 80;
    localparam int unsigned HOLD_OFF_LEN   = 20000;
    localparam int unsigned DRAIN_CYCLES   = 200;

    class totient_scoreboard;
        logic [FIELD_WIDTH-1:0] expected_q[$];
        int unsigned            errors = 0;

        function automatic logic [FIELD_WIDTH-1:0] totient_of(input logic [FIELD_WIDTH-1:0] v);
            longint unsigned n;
            longint unsigned prod;
            longint unsigned d;
            n    = v;
            prod = 1;
            d    = 2;
            if (n == 0)
                return '0;
            while (d <= n / d)
            begin
                if (n % d == 0)
                begin
                    prod = prod * (d - 1);
                    n    = n / d;
                    while (n % d == 0)
                    begin
                        prod = prod * d;
                        n    = n / d;
                    end
                end
                d = (d == 2) ? 3 : d + 2;
            end
            if (n > 1)
                prod = prod * (n - 1);
            return prod[FIELD_WIDTH-1:0];
        endfunction

        function void note_value(input logic [FIELD_WIDTH-1:0] v);
            expected_q.push_back(totient_of(v));
        endfunction

        function void check_totient(input logic [FIELD_WIDTH-1:0] got);
            logic [FIELD_WIDTH-1:0] want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: totient mismatch: expected none, actual %0d", $time, got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t: totient mismatch: expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [FIELD_WIDTH-1:0] value;
    logic                   out_valid;
    logic                   out_ready;
    logic [FIELD_WIDTH-1:0] totient;

    int unsigned send_idle_pct = 19;
    int unsigned recv_idle_pct = 58;
    bit          hold_req      = 1'b0;
    bit          hold_off      = 1'b0;

    totient_scoreboard sb = new();

    euler_totient_trial_division_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .totient   (totient)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_value(input logic [FIELD_WIDTH-1:0] v);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_value(v);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    function automatic logic [FIELD_WIDTH-1:0] pick_value();
        int unsigned            kind;
        int unsigned            w;
        logic [FIELD_WIDTH-1:0] v;
        kind = $urandom_range(99, 0);
        if (kind < 45)
        begin
            // product of small factors: wide values that factor quickly
            v = 1;
            repeat ($urandom_range(4, 1))
                v = v * $urandom_range(255, 1);
        end
        else if (kind < 75)
        begin
            w = $urandom_range(16, 1);
            v = $urandom() & ((32'h1 << w) - 1);
        end
        else if (kind < 95)
        begin
            v = 32'($urandom_range(255, 0)) << $urandom_range(31, 0);
        end
        else
        begin
            v = $urandom_range(32'hFFFFF, 0);
        end
        return v;
    endfunction

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= !hold_off && ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_totient(totient);
    end

    initial
    begin
        wait (hold_req);
        hold_off = 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        logic [FIELD_WIDTH-1:0] corner_values[$];
        corner_values = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd9, 32'd1024,
            32'd30030, 32'd720720, 32'd65521, 32'd999983, 32'd1052651,
            32'hFFFFFFFF, 32'h80000000, 32'hAAAAAAAA, 32'h55555555,
            32'hFFF10000, 32'hFC05FC01, 32'hFFFE0001
        };

        rst_n    = 1'b0;
        in_valid = 1'b0;
        value    = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (corner_values[i])
            send_value(corner_values[i]);

        // hold the sender until the pipeline is empty
        in_valid <= 1'b0;
        @(negedge clk);
        wait_for_drain();

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 19;
            end
            else if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req      = 1'b1;
            end
            send_value(pick_value());
        end

        in_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
